// ===== rtl/knms_pkg.sv =====
// ----------------------------------------------------------------------------
// knms_pkg
// Shared field widths, action codes and register indexes of the keypoint
// suppression table.
// ----------------------------------------------------------------------------
package knms_pkg;

    localparam int RESP_W  = 8;
    localparam int DIAM_W  = 6;
    localparam int ACT_W   = 3;
    localparam int SLOT_W  = 8;
    localparam int TOTAL_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [ACT_W-1:0] ACT_BELOW    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REPLACE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SUPPRESS = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DROP     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RESPONSE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAMETER     = 1'd1;

    localparam logic [RESP_W-1:0] MIN_RESPONSE_RST = 8'd100;
    localparam logic [DIAM_W-1:0] DIAMETER_RST     = 6'd6;

endpackage

// ===== rtl/knms_pix_if.sv =====
// ----------------------------------------------------------------------------
// knms_pix_if
// Pixel item channel: coordinates, response and the frame start flag.
// ----------------------------------------------------------------------------
interface knms_pix_if #(
    parameter int COORD_BITS = 12
);
    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         column;
    logic [COORD_BITS-1:0]         row;
    logic [knms_pkg::RESP_W-1:0]   response;
    logic                          frame_start;

    modport source (output valid, column, row, response, frame_start, input ready);
    modport sink   (input valid, column, row, response, frame_start, output ready);
endinterface

// ===== rtl/knms_res_if.sv =====
// ----------------------------------------------------------------------------
// knms_res_if
// Result item channel: action taken, slot written and table fill.
// ----------------------------------------------------------------------------
interface knms_res_if;
    logic                          valid;
    logic                          ready;
    logic [knms_pkg::ACT_W-1:0]    action;
    logic [knms_pkg::SLOT_W-1:0]   slot;
    logic [knms_pkg::TOTAL_W-1:0]  entry_total;

    modport source (output valid, action, slot, entry_total, input ready);
    modport sink   (input valid, action, slot, entry_total, output ready);
endinterface

// ===== rtl/knms_ram.sv =====
// ----------------------------------------------------------------------------
// knms_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module knms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/knms_sqdiff.sv =====
// ----------------------------------------------------------------------------
// knms_sqdiff
// Shared arithmetic unit: squared absolute difference with a registered
// result, used for the diameter limit and for each coordinate distance.
// ----------------------------------------------------------------------------
module knms_sqdiff #(
    parameter int W = 12
) (
    input  logic           i_clk,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_sq
);
    logic [W-1:0]   diff;
    logic [2*W-1:0] r_sq;

    assign diff = (i_a >= i_b) ? (i_a - i_b) : (i_b - i_a);

    always_ff @(posedge i_clk) begin
        r_sq <= (2*W)'(diff) * (2*W)'(diff);
    end

    assign o_sq = r_sq;
endmodule

// ===== rtl/keypoint_nms_table_core.sv =====
// ----------------------------------------------------------------------------
// keypoint_nms_table_core
// Greedy non-maximum suppression of corner keypoints against a table that
// is scanned in slot order with one shared squared-difference unit.
//
//   channel   direction  payload
//   i_pix     in         column, row, response, frame_start
//   o_res     out        action, slot, entry_total
//   cfg       in         i_cfg_we, i_cfg_idx, i_cfg_data
//
// A pixel at or below the threshold goes straight to the result state. A
// candidate squares the diameter limit, then for each entry scanned reads
// the table RAM and squares the column and row distances in the shared
// squaring unit. Reset clears the fill count and restores the register
// defaults; table contents are not cleared. A waiting result holds the
// block only at the end of the following item.
// ----------------------------------------------------------------------------
module keypoint_nms_table_core #(
    parameter int MAX_ENTRIES = 256,
    parameter int COORD_BITS  = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [knms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [knms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    knms_pix_if.sink                          i_pix,
    knms_res_if.source                        o_res
);
    localparam int RW = knms_pkg::RESP_W;
    localparam int EW = 2 * COORD_BITS + RW;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int MW = (COORD_BITS > knms_pkg::DIAM_W) ? COORD_BITS : knms_pkg::DIAM_W;
    localparam int XW = (CW > knms_pkg::TOTAL_W) ? CW : knms_pkg::TOTAL_W;

    typedef enum logic [3:0] {
        S_IDLE, S_LIM, S_LIMSV, S_NEXT, S_SQX, S_SQY, S_EVAL, S_NOHIT, S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_slot, n_slot;
    logic [knms_pkg::ACT_W-1:0] r_act, n_act;
    logic r_ovl, n_ovl;
    logic [COORD_BITS-1:0] r_col, n_col, r_row, n_row;
    logic [RW-1:0] r_resp, n_resp;
    logic [2*MW-1:0] r_lim, n_lim, r_acc, n_acc;
    logic [RW-1:0] r_min_resp, n_min_resp;
    logic [knms_pkg::DIAM_W-1:0] r_diam, n_diam;
    logic r_out_valid, n_out_valid;
    logic [knms_pkg::ACT_W-1:0] r_out_act, n_out_act;
    logic [knms_pkg::SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [knms_pkg::TOTAL_W-1:0] r_out_total, n_out_total;

    logic [MW-1:0] sq_a, sq_b;
    logic [2*MW-1:0] sq;
    logic [2*MW:0] d2;
    logic ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic [COORD_BITS-1:0] rd_col, rd_row;
    logic [RW-1:0] rd_resp;
    logic overlap;
    logic [XW-1:0] slot_ext, total_ext;

    knms_sqdiff #(.W(MW)) u_sqdiff (
        .i_clk (i_clk),
        .i_a   (sq_a),
        .i_b   (sq_b),
        .o_sq  (sq)
    );

    knms_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_col  = ram_rdata[EW-1 -: COORD_BITS];
    assign rd_row  = ram_rdata[RW +: COORD_BITS];
    assign rd_resp = ram_rdata[RW-1:0];
    assign d2      = {1'b0, r_acc} + {1'b0, sq};
    assign overlap = d2 < {1'b0, r_lim};
    assign slot_ext  = XW'(r_slot);
    assign total_ext = XW'(r_count);
    assign ram_wdata = {r_col, r_row, r_resp};
    assign ram_raddr = r_idx[AW-1:0];

    assign i_pix.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.action      = r_out_act;
    assign o_res.slot        = r_out_slot;
    assign o_res.entry_total = r_out_total;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_slot      = r_slot;
        n_act       = r_act;
        n_ovl       = r_ovl;
        n_col       = r_col;
        n_row       = r_row;
        n_resp      = r_resp;
        n_lim       = r_lim;
        n_acc       = r_acc;
        n_min_resp  = r_min_resp;
        n_diam      = r_diam;
        n_out_valid = r_out_valid;
        n_out_act   = r_out_act;
        n_out_slot  = r_out_slot;
        n_out_total = r_out_total;
        sq_a        = MW'(r_diam);
        sq_b        = '0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_idx[AW-1:0];

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                knms_pkg::CFG_MIN_RESPONSE: n_min_resp = i_cfg_data[RW-1:0];
                knms_pkg::CFG_DIAMETER:     n_diam = i_cfg_data[knms_pkg::DIAM_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_pix.valid) begin
                    n_col  = i_pix.column;
                    n_row  = i_pix.row;
                    n_resp = i_pix.response;
                    n_idx  = '0;
                    n_slot = '0;
                    n_ovl  = 1'b0;
                    if (i_pix.frame_start) begin
                        n_count = '0;
                    end
                    if (i_pix.response > r_min_resp) begin
                        n_state = S_LIM;
                    end else begin
                        n_act   = knms_pkg::ACT_BELOW;
                        n_state = S_FINISH;
                    end
                end
            end
            S_LIM: begin
                n_state = S_LIMSV;
            end
            S_LIMSV: begin
                n_lim   = sq;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (r_idx == r_count) begin
                    n_state = S_NOHIT;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_SQX;
                end
            end
            S_SQX: begin
                sq_a    = MW'(r_col);
                sq_b    = MW'(rd_col);
                n_state = S_SQY;
            end
            S_SQY: begin
                sq_a    = MW'(r_row);
                sq_b    = MW'(rd_row);
                n_acc   = sq;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (overlap && (r_resp > rd_resp)) begin
                    ram_we  = 1'b1;
                    n_slot  = r_idx;
                    n_act   = knms_pkg::ACT_REPLACE;
                    n_state = S_FINISH;
                end else begin
                    n_ovl   = r_ovl | overlap;
                    n_idx   = r_idx + 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NOHIT: begin
                if (r_ovl) begin
                    n_act = knms_pkg::ACT_SUPPRESS;
                end else if (r_count >= CW'(MAX_ENTRIES)) begin
                    n_act = knms_pkg::ACT_DROP;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_count[AW-1:0];
                    n_slot    = r_count;
                    n_count   = r_count + 1'b1;
                    n_act     = knms_pkg::ACT_APPEND;
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_act   = r_act;
                    n_out_slot  = slot_ext[knms_pkg::SLOT_W-1:0];
                    n_out_total = total_ext[knms_pkg::TOTAL_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_min_resp  <= knms_pkg::MIN_RESPONSE_RST;
            r_diam      <= knms_pkg::DIAMETER_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_min_resp  <= n_min_resp;
            r_diam      <= n_diam;
        end
        r_idx       <= n_idx;
        r_slot      <= n_slot;
        r_act       <= n_act;
        r_ovl       <= n_ovl;
        r_col       <= n_col;
        r_row       <= n_row;
        r_resp      <= n_resp;
        r_lim       <= n_lim;
        r_acc       <= n_acc;
        r_out_act   <= n_out_act;
        r_out_slot  <= n_out_slot;
        r_out_total <= n_out_total;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("table fill count exceeds depth");

    a_eval_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_idx < r_count))
        else $error("scan evaluates an entry beyond the fill count");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ({1'b0, ram_waddr} < (AW+1)'(r_count)) || (r_state == S_NOHIT))
        else $error("table write outside the filled range");

    a_below_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready && !(i_pix.response > r_min_resp))
        |=> (r_state == S_FINISH))
        else $error("below-threshold item did not finish at once");
`endif
endmodule
